[rtl/tick_task_scheduler_table_core_assert.svh]
// Assertion macros for the scheduler table core RTL.
`ifndef TICK_TASK_SCHEDULER_TABLE_CORE_ASSERT_SVH
`define TICK_TASK_SCHEDULER_TABLE_CORE_ASSERT_SVH

`ifndef SYNTH
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TTS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/tts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_DISP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    localparam int unsigned HANDLE_W  = 32;
    localparam int unsigned DELAY_W   = 16;
    localparam int unsigned RELOAD_W  = 13;
    localparam int unsigned PENDING_W = 8;
    localparam int unsigned MAX_RUNS  = 8;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [DELAY_W-1:0]   delay;
        logic [RELOAD_W-1:0]  reload;
        logic [PENDING_W-1:0] pending;
    } t_slot;

    typedef struct packed {
        t_cmd cmd;
        logic is_target;
        logic add_ok;
        logic disp_ok;
    } t_op_ctl;

    typedef struct packed {
        logic took_add;
        logic hit_del;
        logic fire;
    } t_op_evt;

    function automatic logic [RELOAD_W-1:0] div10(input logic [DELAY_W-1:0] x);
        logic [31:0] p;
        p = 32'(x) * DIV10_MUL;
        return p[DIV10_SHIFT +: RELOAD_W];
    endfunction

endpackage

`default_nettype wire

[rtl/tts_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module tts_cell (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_en,
    input  tts_pkg::t_slot i_slot,
    output tts_pkg::t_slot o_slot
);

    tts_pkg::t_slot r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_en) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

[rtl/tts_slot_op.sv]
`timescale 1ns / 1ps
`default_nettype none

module tts_slot_op (
    input  tts_pkg::t_slot   i_slot,
    input  tts_pkg::t_op_ctl i_ctl,
    input  tts_pkg::t_slot   i_new,
    output tts_pkg::t_slot   o_slot,
    output tts_pkg::t_op_evt o_evt
);

    logic w_occupied;

    assign w_occupied = (i_slot.handle != '0);

    always_comb begin
        o_slot = i_slot;
        o_evt  = '0;
        case (i_ctl.cmd)
            tts_pkg::CMD_ADD: begin
                if (!w_occupied && i_ctl.add_ok) begin
                    o_evt.took_add = 1'b1;
                    o_slot         = i_new;
                end
            end
            tts_pkg::CMD_DEL: begin
                if (w_occupied && i_ctl.is_target) begin
                    o_evt.hit_del = 1'b1;
                    o_slot        = '0;
                end
            end
            tts_pkg::CMD_TICK: begin
                if (w_occupied) begin
                    if (i_slot.delay == '0) begin
                        if (i_slot.pending != '1) begin
                            o_slot.pending = i_slot.pending + 1'b1;
                        end
                        if (i_slot.reload != '0) begin
                            o_slot.delay = tts_pkg::DELAY_W'(i_slot.reload);
                        end
                    end else begin
                        o_slot.delay = i_slot.delay - 1'b1;
                    end
                end
            end
            tts_pkg::CMD_DISP: begin
                if (i_slot.pending != '0 && i_ctl.disp_ok) begin
                    o_evt.fire     = 1'b1;
                    o_slot.pending = i_slot.pending - 1'b1;
                    // one-shot task leaves the table, remaining runs dropped
                    if (i_slot.reload == '0) begin
                        o_slot = '0;
                    end
                end
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/tick_task_scheduler_table_core.sv]
// Task slot table kept in a ring of SLOT_COUNT cells that rotates past one update unit.
// An accepted beat steps every slot in S_SCAN; S_FINISH then registers its closing beat.
// A new command is taken only in S_IDLE, after the ring has gone round.
// Dispatch runs leave one per firing slot; a push waits while m_axis_tready is low.
// Reset (synchronous, active low) empties every slot and clears the error latch at once.
`timescale 1ns / 1ps
`default_nettype none
`include "tick_task_scheduler_table_core_assert.svh"

module tick_task_scheduler_table_core #(
    parameter int unsigned SLOT_COUNT = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] task_handle, [47:32] first_delay, [63:48] period_ms, [66:64] target_slot
    input  wire  [71:0] s_axis_tdata,
    // [1:0] command
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [1:0] status, [5:2] result_slot, [37:6] run_handle, [38] run_task, [40:39] sticky_error
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                         r_state;
    tts_pkg::t_cmd                  r_cmd;
    logic [tts_pkg::HANDLE_W-1:0]   r_handle;
    logic [tts_pkg::DELAY_W-1:0]    r_delay;
    logic [tts_pkg::RELOAD_W-1:0]   r_reload;
    logic [2:0]                     r_target;
    logic [IW-1:0]                  r_idx;
    logic [3:0]                     r_n;
    logic                           r_found;
    logic [IW-1:0]                  r_add_slot;
    logic                           r_del_hit;
    logic                           r_hold_valid;
    logic [IW-1:0]                  r_hold_slot;
    logic [tts_pkg::HANDLE_W-1:0]   r_hold_handle;
    tts_pkg::t_status               r_err;

    logic                           r_out_valid;
    tts_pkg::t_status               r_o_status;
    logic [3:0]                     r_o_slot;
    logic [tts_pkg::HANDLE_W-1:0]   r_o_handle;
    logic                           r_o_run;
    logic                           r_o_last;
    tts_pkg::t_status               r_o_sticky;

    logic                           n_out_valid;
    tts_pkg::t_status               n_o_status;
    logic [3:0]                     n_o_slot;
    logic [tts_pkg::HANDLE_W-1:0]   n_o_handle;
    logic                           n_o_run;
    logic                           n_o_last;
    tts_pkg::t_status               n_o_sticky;
    tts_pkg::t_status               n_err;

    tts_pkg::t_slot   w_cell_q [SLOT_COUNT];
    tts_pkg::t_slot   w_cell_d [SLOT_COUNT];
    tts_pkg::t_slot   w_op_slot;
    tts_pkg::t_slot   w_new;
    tts_pkg::t_op_ctl w_ctl;
    tts_pkg::t_op_evt w_evt;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_push_need;
    logic             w_step;
    logic             w_shift;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_new = '{handle: r_handle, delay: r_delay, reload: r_reload, pending: '0};

    assign w_ctl.cmd       = r_cmd;
    assign w_ctl.is_target = (32'(r_target) == 32'(r_idx));
    assign w_ctl.add_ok    = !r_found;
    assign w_ctl.disp_ok   = (32'(r_n) < tts_pkg::MAX_RUNS);

    tts_slot_op u_op (
        .i_slot (w_cell_q[0]),
        .i_ctl  (w_ctl),
        .i_new  (w_new),
        .o_slot (w_op_slot),
        .o_evt  (w_evt)
    );

    // a new dispatch hit pushes out the held one, so it needs room at the output
    assign w_push_need = w_evt.fire && r_hold_valid;
    assign w_step      = !w_push_need || w_out_free;
    assign w_shift     = (r_state == S_SCAN) && w_step;

    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
        if (k == SLOT_COUNT - 1) begin : g_tail
            assign w_cell_d[k] = w_op_slot;
        end else begin : g_body
            assign w_cell_d[k] = w_cell_q[k+1];
        end
        tts_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_shift),
            .i_slot  (w_cell_d[k]),
            .o_slot  (w_cell_q[k])
        );
    end

    // load the output register with a pushed run or with the closing beat
    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_handle  = r_o_handle;
        n_o_run     = r_o_run;
        n_o_last    = r_o_last;
        n_o_sticky  = r_o_sticky;
        n_err       = r_err;
        if ((r_state == S_SCAN) && w_step && w_push_need) begin
            n_out_valid = 1'b1;
            n_o_status  = tts_pkg::STS_OK;
            n_o_slot    = 4'(r_hold_slot);
            n_o_handle  = r_hold_handle;
            n_o_run     = 1'b1;
            n_o_last    = 1'b0;
            n_o_sticky  = r_err;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            n_out_valid = 1'b1;
            n_o_status  = tts_pkg::STS_OK;
            n_o_slot    = '0;
            n_o_handle  = '0;
            n_o_run     = 1'b0;
            n_o_last    = 1'b1;
            case (r_cmd)
                tts_pkg::CMD_ADD: begin
                    if (r_found) begin
                        n_o_slot = 4'(r_add_slot);
                    end else begin
                        n_o_status = tts_pkg::STS_FULL;
                        n_o_slot   = 4'(SLOT_COUNT);
                        n_err      = tts_pkg::STS_FULL;
                    end
                end
                tts_pkg::CMD_DEL: begin
                    n_o_slot = 4'(r_target);
                    if (!r_del_hit) begin
                        n_o_status = tts_pkg::STS_EMPTY;
                        n_err      = tts_pkg::STS_EMPTY;
                    end
                end
                tts_pkg::CMD_DISP: begin
                    if (r_hold_valid) begin
                        n_o_slot   = 4'(r_hold_slot);
                        n_o_handle = r_hold_handle;
                        n_o_run    = 1'b1;
                    end
                end
                default: begin
                    n_o_slot = '0;
                end
            endcase
            n_o_sticky = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_err        <= tts_pkg::STS_OK;
            r_hold_valid <= 1'b0;
            r_found      <= 1'b0;
            r_del_hit    <= 1'b0;
            r_n          <= '0;
            r_idx        <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_o_status  <= n_o_status;
            r_o_slot    <= n_o_slot;
            r_o_handle  <= n_o_handle;
            r_o_run     <= n_o_run;
            r_o_last    <= n_o_last;
            r_o_sticky  <= n_o_sticky;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd        <= tts_pkg::t_cmd'(s_axis_tuser);
                        r_handle     <= s_axis_tdata[31:0];
                        r_delay      <= s_axis_tdata[47:32];
                        r_reload     <= tts_pkg::div10(s_axis_tdata[63:48]);
                        r_target     <= s_axis_tdata[66:64];
                        r_idx        <= '0;
                        r_n          <= '0;
                        r_found      <= 1'b0;
                        r_del_hit    <= 1'b0;
                        r_hold_valid <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_step) begin
                        if (w_evt.took_add) begin
                            r_found    <= 1'b1;
                            r_add_slot <= r_idx;
                        end
                        if (w_evt.hit_del) begin
                            r_del_hit <= 1'b1;
                        end
                        if (w_evt.fire) begin
                            r_hold_valid  <= 1'b1;
                            r_hold_slot   <= r_idx;
                            r_hold_handle <= w_cell_q[0].handle;
                            r_n           <= r_n + 1'b1;
                        end
                        if (r_idx == IW'(SLOT_COUNT - 1)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_hold_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {7'b0, r_o_sticky, r_o_run, r_o_handle, r_o_slot, r_o_status};

    `TTS_ASSERT(a_run_limit, i_clk, i_rst_n, r_n <= 4'(tts_pkg::MAX_RUNS), "run count overflow")
    `TTS_ASSERT(a_found_add, i_clk, i_rst_n, r_found |-> r_cmd == tts_pkg::CMD_ADD, "stray add")
    `TTS_ASSERT(a_hit_del, i_clk, i_rst_n, r_del_hit |-> r_cmd == tts_pkg::CMD_DEL, "stray delete")
    `TTS_ASSERT(a_out_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) != S_IDLE, "idle beat")
    `TTS_ASSERT_NEVER(a_ready_busy, i_clk, i_rst_n, s_axis_tready && r_hold_valid, "stale hold")

endmodule

`default_nettype wire
